[sv/bdc_pkg.sv]
// Package for the debounced button block: configuration and result types,
// register indices and reset values. Depends on nothing.
`default_nettype none

package bdc_pkg;

    localparam int unsigned CfgWidth    = 16;
    localparam int unsigned TimeWidth   = 32;
    localparam int unsigned CfgIdxWidth = 8;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_SETTLING_TIME        = 8'd0,
        CFG_LONG_PRESS_THRESHOLD = 8'd1,
        CFG_LONG_PRESS_INTERVAL  = 8'd2,
        CFG_CLICK_INTERVAL       = 8'd3
    } cfg_index_t;

    localparam logic [CfgWidth-1:0] SETTLING_TIME_RST        = 16'd10;
    localparam logic [CfgWidth-1:0] LONG_PRESS_THRESHOLD_RST = 16'd1000;
    localparam logic [CfgWidth-1:0] LONG_PRESS_INTERVAL_RST  = 16'd100;
    localparam logic [CfgWidth-1:0] CLICK_INTERVAL_RST       = 16'd200;

    localparam logic [15:0] HOLD_REPEATS_MAX = 16'hFFFF;
    localparam logic [7:0]  CLICK_COUNT_MAX  = 8'hFF;

    typedef struct packed {
        logic [CfgWidth-1:0] settling_time;
        logic [CfgWidth-1:0] long_press_threshold;
        logic [CfgWidth-1:0] long_press_interval;
        logic [CfgWidth-1:0] click_interval;
    } cfg_t;

    typedef struct packed {
        logic        stable_level;
        logic        press_event;
        logic        release_event;
        logic        long_press_event;
        logic [15:0] long_press_count;
        logic        click_event;
        logic [7:0]  click_total;
    } result_t;

endpackage

`default_nettype wire

[sv/bdc_stream_if.sv]
// Valid/ready channel interfaces for the debounced button block: the poll
// channel and the result channel. No dependencies.
`default_nettype none

interface bdc_poll_if;
    logic        valid;
    logic        ready;
    logic        pin_level;
    logic [31:0] now;

    modport source (output valid, output pin_level, output now, input ready);
    modport sink   (input valid, input pin_level, input now, output ready);
endinterface

interface bdc_result_if;
    logic        valid;
    logic        ready;
    logic        stable_level;
    logic        press_event;
    logic        release_event;
    logic        long_press_event;
    logic [15:0] long_press_count;
    logic        click_event;
    logic [7:0]  click_total;

    modport source (output valid, output stable_level, output press_event,
                    output release_event, output long_press_event,
                    output long_press_count, output click_event,
                    output click_total, input ready);
    modport sink   (input valid, input stable_level, input press_event,
                    input release_event, input long_press_event,
                    input long_press_count, input click_event,
                    input click_total, output ready);
endinterface

`default_nettype wire

[sv/bdc_engine.sv]
// Debounce, long-press and click state with its single-pass update logic.
// Depends on bdc_pkg.
`default_nettype none

module bdc_engine (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic             pin_level,
    input  wire logic [31:0]      now,
    input  wire bdc_pkg::cfg_t    cfg,
    output bdc_pkg::result_t      result
);
    import bdc_pkg::*;

    logic        debounced_reg, debounced_next;
    logic        pending_reg, pending_next;
    logic [31:0] pending_since_reg, pending_since_next;
    logic [31:0] pressed_at_reg, pressed_at_next;
    logic [31:0] released_at_reg, released_at_next;
    logic [15:0] hold_repeats_reg, hold_repeats_next;
    logic [31:0] last_repeat_reg, last_repeat_next;
    logic [7:0]  click_count_reg, click_count_next;

    always_comb
    begin
        logic [31:0] since_pending;
        logic [31:0] held_time;
        logic [31:0] since_repeat;
        logic [31:0] since_release;

        debounced_next     = debounced_reg;
        pending_next       = pending_reg;
        pending_since_next = pending_since_reg;
        pressed_at_next    = pressed_at_reg;
        released_at_next   = released_at_reg;
        hold_repeats_next  = hold_repeats_reg;
        last_repeat_next   = last_repeat_reg;
        click_count_next   = click_count_reg;
        result             = '0;

        since_pending = now - pending_since_reg;
        if (pending_reg)
        begin
            if (since_pending >= {16'd0, cfg.settling_time})
            begin
                if (pin_level != debounced_reg)
                begin
                    if (pin_level)
                    begin
                        result.press_event = 1'b1;
                        pressed_at_next    = now;
                    end
                    else
                    begin
                        result.release_event = 1'b1;
                        released_at_next     = now;
                        hold_repeats_next    = '0;
                        if ((now - pressed_at_reg) < {16'd0, cfg.long_press_threshold})
                        begin
                            if (click_count_reg != CLICK_COUNT_MAX)
                            begin
                                click_count_next = click_count_reg + 8'd1;
                            end
                        end
                        else
                        begin
                            click_count_next = '0;
                        end
                    end
                end
                debounced_next = pin_level;
                pending_next   = 1'b0;
            end
        end
        else if (pin_level != debounced_reg)
        begin
            pending_next       = 1'b1;
            pending_since_next = now;
        end

        held_time    = now - pressed_at_next;
        since_repeat = now - last_repeat_reg;
        if (debounced_next)
        begin
            if (hold_repeats_next == '0)
            begin
                if (held_time > {16'd0, cfg.long_press_threshold})
                begin
                    hold_repeats_next       = 16'd1;
                    result.long_press_event = 1'b1;
                    last_repeat_next        = now;
                end
            end
            else if (since_repeat > {16'd0, cfg.long_press_interval})
            begin
                last_repeat_next = now;
                if (hold_repeats_next != HOLD_REPEATS_MAX)
                begin
                    hold_repeats_next = hold_repeats_next + 16'd1;
                end
                result.long_press_event = 1'b1;
            end
        end

        since_release = now - released_at_next;
        if ((click_count_next != '0) && !debounced_next
            && (since_release > {16'd0, cfg.click_interval}))
        begin
            result.click_event = 1'b1;
            result.click_total = click_count_next;
            click_count_next   = '0;
        end

        result.stable_level     = debounced_next;
        result.long_press_count = hold_repeats_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounced_reg     <= 1'b0;
            pending_reg       <= 1'b0;
            pending_since_reg <= '0;
            pressed_at_reg    <= '0;
            released_at_reg   <= '0;
            hold_repeats_reg  <= '0;
            last_repeat_reg   <= '0;
            click_count_reg   <= '0;
        end
        else if (step)
        begin
            debounced_reg     <= debounced_next;
            pending_reg       <= pending_next;
            pending_since_reg <= pending_since_next;
            pressed_at_reg    <= pressed_at_next;
            released_at_reg   <= released_at_next;
            hold_repeats_reg  <= hold_repeats_next;
            last_repeat_reg   <= last_repeat_next;
            click_count_reg   <= click_count_next;
        end
    end

`ifndef SYNTH
    // The hold count is only ever non-zero while the debounced level is high.
    a_hold_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_repeats_reg != '0) |-> debounced_reg)
        else $error("hold count set while released");

    // A settled press or release must change the debounced level accordingly.
    a_press_sets_level: assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.press_event) |=> debounced_reg)
        else $error("press event did not raise the debounced level");

    a_release_clears_level: assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.release_event) |=> !debounced_reg)
        else $error("release event did not clear the debounced level");
`endif

endmodule

`default_nettype wire

[sv/button_debounce_click_longpress_top.sv]
// Top level of the debounced button block: configuration registers, poll
// input register and result register. Depends on bdc_pkg, bdc_stream_if, bdc_engine.
`default_nettype none

// Debounced push button with multi-click and long-press detection. Each poll
// transaction carries the raw pin level and a wrapping 32-bit tick count and
// produces exactly one result transaction. A poll passes through an input
// register and one pass of update logic into the result register, so the
// block takes one poll per clock cycle while results are taken as they come.
// A poll waits in the input register while an untaken result holds the result
// register. Configuration writes take effect on the next poll and should be
// made while no poll is in flight.
module button_debounce_click_longpress_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    bdc_poll_if.sink                            poll,
    bdc_result_if.source                        result,
    input  wire logic                           cfg_we,
    input  wire logic [bdc_pkg::CfgIdxWidth-1:0] cfg_index,
    input  wire logic [bdc_pkg::CfgWidth-1:0]    cfg_data
);
    import bdc_pkg::*;

    cfg_t        cfg_reg;
    logic        poll_valid_reg;
    logic        pin_level_reg;
    logic [31:0] now_reg;
    logic        res_valid_reg;
    result_t     res_reg;
    result_t     res_next;
    logic        advance;
    logic        poll_accept;

    assign advance     = poll_valid_reg && (!res_valid_reg || result.ready);
    assign poll.ready  = !poll_valid_reg || advance;
    assign poll_accept = poll.valid && poll.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settling_time        <= SETTLING_TIME_RST;
            cfg_reg.long_press_threshold <= LONG_PRESS_THRESHOLD_RST;
            cfg_reg.long_press_interval  <= LONG_PRESS_INTERVAL_RST;
            cfg_reg.click_interval       <= CLICK_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SETTLING_TIME:        cfg_reg.settling_time        <= cfg_data;
                CFG_LONG_PRESS_THRESHOLD: cfg_reg.long_press_threshold <= cfg_data;
                CFG_LONG_PRESS_INTERVAL:  cfg_reg.long_press_interval  <= cfg_data;
                CFG_CLICK_INTERVAL:       cfg_reg.click_interval       <= cfg_data;
                default:                  cfg_reg                      <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (poll_accept)
            begin
                poll_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                poll_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_accept)
        begin
            pin_level_reg <= poll.pin_level;
            now_reg       <= poll.now;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    bdc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .pin_level (pin_level_reg),
        .now       (now_reg),
        .cfg       (cfg_reg),
        .result    (res_next)
    );

    assign result.valid            = res_valid_reg;
    assign result.stable_level     = res_reg.stable_level;
    assign result.press_event      = res_reg.press_event;
    assign result.release_event    = res_reg.release_event;
    assign result.long_press_event = res_reg.long_press_event;
    assign result.long_press_count = res_reg.long_press_count;
    assign result.click_event      = res_reg.click_event;
    assign result.click_total      = res_reg.click_total;

`ifndef SYNTH
    // Press and release cannot both be reported for one poll.
    a_press_release_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_reg.press_event && res_reg.release_event))
        else $error("press and release reported together");

    // Long-press events only occur while held, with a non-zero count.
    a_long_press_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.long_press_event)
            |-> (res_reg.stable_level && (res_reg.long_press_count != '0)))
        else $error("long press reported while released");

    // A click burst is reported only while released and is never empty.
    a_click_released: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.click_event)
            |-> (!res_reg.stable_level && (res_reg.click_total != '0)))
        else $error("click burst reported while held or empty");

    // A waiting result must stop the input stage from running over it.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !result.ready && poll_valid_reg) |-> !poll.ready)
        else $error("poll accepted while result stage is blocked");
`endif

endmodule

`default_nettype wire

[test/button_debounce_click_longpress_top_test.sv]
// Self-checking testbench for button_debounce_click_longpress_top: it drives
// poll transactions with bursty timing, predicts every result and compares it.
// Depends on bdc_pkg, bdc_stream_if and the top level of the block.
`timescale 1ns / 100ps

module button_debounce_click_longpress_top_test;
    import bdc_pkg::*;

    localparam int unsigned IdleLimit      = 2000;
    localparam int unsigned PollsPerSetting = 75;

    typedef enum int unsigned {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_LONG
    } stall_style_t;

    class click_scoreboard;
        cfg_t        settings;
        logic        level;
        logic        change_waiting;
        logic [31:0] waiting_since;
        logic [31:0] pressed_at;
        logic [31:0] released_at;
        logic [31:0] last_repeat_at;
        logic [15:0] repeats;
        logic [7:0]  clicks;
        result_t     expected_results[$];
        int unsigned errors;
        int unsigned polls;
        int unsigned presses;
        int unsigned long_presses;
        int unsigned click_bursts;
        int unsigned largest_burst;

        function new();
            settings = cfg_t'{SETTLING_TIME_RST, LONG_PRESS_THRESHOLD_RST,
                              LONG_PRESS_INTERVAL_RST, CLICK_INTERVAL_RST};
            level          = 1'b0;
            change_waiting = 1'b0;
            waiting_since  = '0;
            pressed_at     = '0;
            released_at    = '0;
            last_repeat_at = '0;
            repeats        = '0;
            clicks         = '0;
            errors         = 0;
            polls          = 0;
            presses        = 0;
            long_presses   = 0;
            click_bursts   = 0;
            largest_burst  = 0;
        endfunction

        function void write_register(logic [CfgIdxWidth-1:0] index,
                                     logic [CfgWidth-1:0] data);
            case (index)
                CFG_SETTLING_TIME:        settings.settling_time = data;
                CFG_LONG_PRESS_THRESHOLD: settings.long_press_threshold = data;
                CFG_LONG_PRESS_INTERVAL:  settings.long_press_interval = data;
                CFG_CLICK_INTERVAL:       settings.click_interval = data;
                default: ;
            endcase
        endfunction

        function void note_poll(logic pin, logic [31:0] now);
            result_t     report;
            logic [31:0] elapsed;
            report = '0;
            if (change_waiting) begin
                elapsed = now - waiting_since;
                if (elapsed >= settings.settling_time) begin
                    if (pin != level) begin
                        if (pin) begin
                            report.press_event = 1'b1;
                            pressed_at = now;
                        end
                        else begin
                            report.release_event = 1'b1;
                            released_at = now;
                            repeats = '0;
                            elapsed = released_at - pressed_at;
                            if (elapsed < settings.long_press_threshold) begin
                                if (clicks != CLICK_COUNT_MAX)
                                    clicks = clicks + 8'd1;
                            end
                            else
                                clicks = '0;
                        end
                    end
                    level = pin;
                    change_waiting = 1'b0;
                end
            end
            else if (pin != level) begin
                change_waiting = 1'b1;
                waiting_since = now;
            end

            if (level) begin
                if (repeats == '0) begin
                    elapsed = now - pressed_at;
                    if (elapsed > settings.long_press_threshold) begin
                        repeats = 16'd1;
                        report.long_press_event = 1'b1;
                        last_repeat_at = now;
                    end
                end
                else begin
                    elapsed = now - last_repeat_at;
                    if (elapsed > settings.long_press_interval) begin
                        last_repeat_at = now;
                        if (repeats != HOLD_REPEATS_MAX)
                            repeats = repeats + 16'd1;
                        report.long_press_event = 1'b1;
                    end
                end
            end

            elapsed = now - released_at;
            if (clicks != '0 && !level && elapsed > settings.click_interval) begin
                report.click_event = 1'b1;
                report.click_total = clicks;
                clicks = '0;
            end

            report.stable_level     = level;
            report.long_press_count = repeats;
            expected_results.push_back(report);
            polls++;
            presses += report.press_event;
            long_presses += report.long_press_event;
            click_bursts += report.click_event;
            if (report.click_total > largest_burst)
                largest_burst = report.click_total;
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                $error("result transaction arrived with no poll outstanding");
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("stable_level", want.stable_level, got.stable_level);
            compare_field("press_event", want.press_event, got.press_event);
            compare_field("release_event", want.release_event, got.release_event);
            compare_field("long_press_event", want.long_press_event, got.long_press_event);
            compare_field("long_press_count", want.long_press_count, got.long_press_count);
            compare_field("click_event", want.click_event, got.click_event);
            compare_field("click_total", want.click_total, got.click_total);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CfgIdxWidth-1:0] cfg_index;
    logic [CfgWidth-1:0]    cfg_data;

    bdc_poll_if   poll_ch();
    bdc_result_if result_ch();

    click_scoreboard tracker;
    logic [31:0]     tick;
    int unsigned     step_max;
    int unsigned     gap_max;
    int unsigned     burst_left = 0;
    int unsigned     settings_used = 0;
    int unsigned     idle_cycles = 0;
    int unsigned     stall_left = 0;
    int unsigned     stall_phase = 0;
    stall_style_t    stall_style = STALL_NONE;

    button_debounce_click_longpress_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .poll      (poll_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin : receive_side
        result_t got;
        if (rst_n) begin
            if (result_ch.valid && result_ch.ready) begin
                got.stable_level     = result_ch.stable_level;
                got.press_event      = result_ch.press_event;
                got.release_event    = result_ch.release_event;
                got.long_press_event = result_ch.long_press_event;
                got.long_press_count = result_ch.long_press_count;
                got.click_event      = result_ch.click_event;
                got.click_total      = result_ch.click_total;
                tracker.check_result(got);
            end
            case (stall_style)
                STALL_NONE:
                    result_ch.ready <= 1'b1;
                STALL_RANDOM:
                    result_ch.ready <= ($urandom_range(0, 3) != 0);
                STALL_PERIODIC:
                begin
                    stall_phase = (stall_phase + 1) % 7;
                    result_ch.ready <= !(stall_phase == 1 || stall_phase == 4);
                end
                default:
                begin
                    if (stall_left != 0) begin
                        stall_left--;
                        result_ch.ready <= 1'b0;
                    end
                    else if ($urandom_range(0, 9) == 0) begin
                        stall_left = $urandom_range(1, 6);
                        result_ch.ready <= 1'b0;
                    end
                    else
                        result_ch.ready <= 1'b1;
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (poll_ch.valid && poll_ch.ready)
                   || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles == IdleLimit) begin
            $display("No transaction for %0d cycles, giving up.", IdleLimit);
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_poll(input logic pin, input logic [31:0] now);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0) begin
                poll_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        poll_ch.valid     <= 1'b1;
        poll_ch.pin_level <= pin;
        poll_ch.now       <= now;
        do
            @(posedge clk);
        while (poll_ch.ready !== 1'b1);
        tracker.note_poll(pin, now);
    endtask

    task automatic drain_results();
        poll_ch.valid <= 1'b0;
        burst_left = 0;
        while (tracker.expected_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic put_register(input logic [CfgIdxWidth-1:0] index,
                                input logic [CfgWidth-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        tracker.write_register(index, data);
    endtask

    task automatic apply_settings(input cfg_t c);
        drain_results();
        put_register(CFG_SETTLING_TIME, c.settling_time);
        put_register(CFG_LONG_PRESS_THRESHOLD, c.long_press_threshold);
        put_register(CFG_LONG_PRESS_INTERVAL, c.long_press_interval);
        put_register(CFG_CLICK_INTERVAL, c.click_interval);
        // An index past the last register must leave every setting alone.
        put_register(CfgIdxWidth'($urandom_range(CFG_CLICK_INTERVAL + 1,
                                                 (1 << CfgIdxWidth) - 1)),
                     CfgWidth'($urandom));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic void advance_tick();
        if ($urandom_range(0, 299) == 0)
            tick += $urandom;
        else
            tick += $urandom_range(0, step_max);
    endfunction

    task automatic hold_level(input logic pin, input int unsigned span);
        logic [31:0] start;
        start = tick;
        do begin
            send_poll(pin, tick);
            advance_tick();
        end while (tick - start < span);
    endtask

    task automatic bounce();
        repeat ($urandom_range(0, 4)) begin
            send_poll($urandom_range(0, 1), tick);
            advance_tick();
        end
    endtask

    task automatic button_gesture();
        int unsigned settle;
        int unsigned thr;
        int unsigned held;
        int unsigned rest;
        settle = tracker.settings.settling_time;
        thr    = tracker.settings.long_press_threshold;
        held   = settle + ($urandom_range(0, 1) ? $urandom_range(0, thr)
                 : thr + $urandom_range(0, 3 * tracker.settings.long_press_interval + 2));
        rest   = settle + ($urandom_range(0, 1)
                 ? $urandom_range(0, tracker.settings.click_interval)
                 : tracker.settings.click_interval
                   + $urandom_range(1, tracker.settings.click_interval));
        bounce();
        hold_level(1'b1, held);
        bounce();
        hold_level(1'b0, rest);
    endtask

    task automatic run_setting(input cfg_t c, input int unsigned step,
                               input int unsigned gap);
        int unsigned first;
        apply_settings(c);
        step_max    = step;
        gap_max     = gap;
        stall_style = stall_style_t'(settings_used % 4);
        tick += $urandom;
        first = tracker.polls;
        while (tracker.polls - first < PollsPerSetting) begin
            case ($urandom_range(0, 15))
                0:
                    repeat ($urandom_range(3, 15)) begin
                        send_poll($urandom_range(0, 1), tick);
                        advance_tick();
                    end
                1:
                    drain_results();
                default:
                    button_gesture();
            endcase
        end
    endtask

    task automatic directed_polls();
        send_poll(1'b1, 32'd0);
        send_poll(1'b1, 32'd9);
        send_poll(1'b1, 32'd10);
        send_poll(1'b0, 32'd15);
        send_poll(1'b1, 32'd25);
        send_poll(1'b1, 32'd1010);
        send_poll(1'b1, 32'd1011);
        send_poll(1'b1, 32'd1111);
        send_poll(1'b1, 32'd1112);
        send_poll(1'b0, 32'd1120);
        send_poll(1'b0, 32'd1130);
        send_poll(1'b1, 32'd1200);
        send_poll(1'b1, 32'd1210);
        send_poll(1'b0, 32'd1300);
        send_poll(1'b0, 32'd1310);
        send_poll(1'b1, 32'd1400);
        send_poll(1'b1, 32'd1410);
        send_poll(1'b0, 32'd1420);
        send_poll(1'b0, 32'd1430);
        send_poll(1'b0, 32'd1630);
        send_poll(1'b0, 32'd1631);
        send_poll(1'b1, 32'hFFFF_FFF8);
        send_poll(1'b1, 32'h0000_0002);
        send_poll(1'b0, 32'h0000_000A);
    endtask

    task automatic saturate_counters();
        apply_settings(cfg_t'{16'd0, 16'hFFFF, 16'd1, 16'hFFFF});
        gap_max     = 0;
        stall_style = STALL_NONE;
        tick = $urandom;
        repeat (260) begin
            send_poll(1'b1, tick);
            send_poll(1'b1, tick + 32'd1);
            send_poll(1'b0, tick + 32'd2);
            send_poll(1'b0, tick + 32'd3);
            tick += 32'd4;
        end
        tick += 32'h0001_0005;
        send_poll(1'b0, tick);
    endtask

    initial
    begin
        cfg_t drawn;
        tracker = new();
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        poll_ch.valid     = 1'b0;
        poll_ch.pin_level = 1'b0;
        poll_ch.now       = '0;
        result_ch.ready   = 1'b0;
        tick              = '0;
        step_max          = 1;
        gap_max           = 3;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        stall_style = STALL_RANDOM;
        directed_polls();

        run_setting(cfg_t'{SETTLING_TIME_RST, LONG_PRESS_THRESHOLD_RST,
                           LONG_PRESS_INTERVAL_RST, CLICK_INTERVAL_RST}, 60, 4);
        run_setting(cfg_t'{16'd3, 16'd40, 16'd8, 16'd25}, 4, 3);
        run_setting(cfg_t'{16'd0, 16'd1, 16'd1, 16'd1}, 2, 6);
        run_setting(cfg_t'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 9000, 2);
        repeat (2) begin
            drawn.settling_time        = $urandom_range(0, 20);
            drawn.long_press_threshold = $urandom_range(1, 150);
            drawn.long_press_interval  = $urandom_range(1, 40);
            drawn.click_interval       = $urandom_range(1, 90);
            run_setting(drawn, drawn.long_press_threshold / 8 + 2, 5);
        end
        run_setting(cfg_t'{16'd12, 16'd300, 16'd50, 16'd100}, 25, 8);
        saturate_counters();

        drain_results();
        repeat (6) @(posedge clk);
        $display("Ran %0d polls under %0d register settings: %0d presses, %0d long-press",
                 tracker.polls, settings_used, tracker.presses, tracker.long_presses);
        $display("events and %0d click bursts, the largest of %0d clicks.",
                 tracker.click_bursts, tracker.largest_burst);
        if (tracker.errors == 0 && tracker.expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
sv/bdc_pkg.sv
sv/bdc_stream_if.sv
sv/bdc_engine.sv
sv/button_debounce_click_longpress_top.sv
test/button_debounce_click_longpress_top_test.sv
